>>> design/pidc_pkg.sv
package pidc_pkg;

    localparam int DataW    = 32;
    localparam int CfgIdxW  = 3;
    localparam int LimitW   = 31;
    localparam int DtW      = 17;
    localparam int IntegW   = 21;
    localparam int MulW     = 33;
    localparam int ProdW    = 2 * MulW;
    localparam int DivNumW  = 49;
    localparam int DivSteps = 49;
    localparam int DivCntW  = 6;
    localparam int OutW     = 88;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_SETPOINT  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_GAIN_P    = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_GAIN_I    = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_GAIN_D    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_OUT_LIMIT = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_STEP_TIME = 3'd5;

    localparam logic [LimitW-1:0] LimitReset = 31'd6553600;
    localparam logic [DtW-1:0]    DtDefault  = 17'd655;
    localparam logic signed [34:0] IntegMax  = 35'sd720896;

    typedef logic signed [MulW-1:0]  mul_op_t;
    typedef logic signed [ProdW-1:0] mul_prod_t;

endpackage

>>> design/pid_controller_clamped.sv
// Channel  Dir  Width  Contents (lowest bit first)
// s_axis   in   32+1   tdata: measured; tuser: opcode (1 = clear)
// m_axis   out  88     tdata: drive, error_now, integral_now, zero pad
// cfg      in   3+32   cfg_index selects the register, cfg_data holds the value
//
// A control step raises m_tvalid once the 49-step serial divider for the derivative
// is done, and the next transfer is taken only back in idle; the shared multiplier
// forms the increment, P and I products meanwhile.
// A clear goes straight to the output state and raises m_tvalid from there.
// Reset restores the configuration and controller state and empties the output.
// A result held by m_tready stalls the sequencer in its last state only.
module pid_controller_clamped (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pidc_pkg::DataW-1:0]      s_tdata,   // [31:0] measured
    input  logic [0:0]                      s_tuser,   // [0] opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pidc_pkg::OutW-1:0]       m_tdata,   // [31:0] drive, [63:32] error_now,
                                                       // [84:64] integral_now
    input  logic                            cfg_we,
    input  logic [pidc_pkg::CfgIdxW-1:0]    cfg_index,
    input  logic [pidc_pkg::DataW-1:0]      cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_INC  = 4'd1;
    localparam logic [3:0] S_INCA = 4'd2;
    localparam logic [3:0] S_PA   = 4'd3;
    localparam logic [3:0] S_IA   = 4'd4;
    localparam logic [3:0] S_DW   = 4'd5;
    localparam logic [3:0] S_DA   = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    logic signed [pidc_pkg::DataW-1:0]  setpoint_reg;
    logic signed [pidc_pkg::DataW-1:0]  gain_p_reg;
    logic signed [pidc_pkg::DataW-1:0]  gain_i_reg;
    logic signed [pidc_pkg::DataW-1:0]  gain_d_reg;
    logic [pidc_pkg::LimitW-1:0]        out_limit_reg;
    logic [pidc_pkg::DtW-1:0]           step_time_reg;

    logic signed [pidc_pkg::DataW-1:0]  prev_reg;
    logic signed [pidc_pkg::IntegW-1:0] integ_reg;
    logic signed [pidc_pkg::DataW-1:0]  err_reg;
    logic signed [33:0]                 acc_reg;

    logic                               m_tvalid_reg;
    logic [pidc_pkg::OutW-1:0]          m_tdata_reg;

    logic                               s_xfer;
    logic signed [32:0]                 diff_in;
    logic signed [pidc_pkg::DataW-1:0]  err_in;
    logic [pidc_pkg::DtW-1:0]           dt;
    logic signed [32:0]                 err_delta;
    logic [32:0]                        delta_mag;

    pidc_pkg::mul_op_t                  mul_a;
    pidc_pkg::mul_op_t                  mul_b;
    pidc_pkg::mul_prod_t                prod;

    logic                               div_start;
    logic                               div_busy;
    logic signed [pidc_pkg::DataW-1:0]  div_q;

    logic signed [pidc_pkg::ProdW-1:0]  term_bias;
    logic signed [pidc_pkg::ProdW-1:0]  term_shift;
    logic signed [pidc_pkg::DataW-1:0]  term;
    logic signed [pidc_pkg::ProdW-1:0]  inc_bias;
    logic signed [pidc_pkg::ProdW-1:0]  inc_shift;
    logic signed [34:0]                 integ_sum;
    logic signed [pidc_pkg::IntegW-1:0] integ_new;
    logic signed [33:0]                 lim;
    logic signed [33:0]                 drive_w;
    logic                               out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg  <= '0;
            gain_p_reg    <= '0;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            out_limit_reg <= pidc_pkg::LimitReset;
            step_time_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pidc_pkg::REG_SETPOINT:  setpoint_reg  <= $signed(cfg_data);
                pidc_pkg::REG_GAIN_P:    gain_p_reg    <= $signed(cfg_data);
                pidc_pkg::REG_GAIN_I:    gain_i_reg    <= $signed(cfg_data);
                pidc_pkg::REG_GAIN_D:    gain_d_reg    <= $signed(cfg_data);
                pidc_pkg::REG_OUT_LIMIT: out_limit_reg <= cfg_data[pidc_pkg::LimitW-1:0];
                pidc_pkg::REG_STEP_TIME: step_time_reg <= cfg_data[pidc_pkg::DtW-1:0];
                default: ;
            endcase
        end
    end

    // error and divider operands
    always_comb
    begin
        diff_in = {setpoint_reg[31], setpoint_reg} - {s_tdata[31], s_tdata};
        if (diff_in[32] != diff_in[31])
            err_in = diff_in[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            err_in = diff_in[31:0];
        dt        = (step_time_reg == '0) ? pidc_pkg::DtDefault : step_time_reg;
        err_delta = {err_reg[31], err_reg} - {prev_reg[31], prev_reg};
        delta_mag = err_delta[32] ? 33'(-err_delta) : 33'(err_delta);
    end

    assign div_start = (state_reg == S_INC);

    pidc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({delta_mag, 16'b0}),
        .divisor  (dt),
        .negative (err_delta[32]),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_INC:
            begin
                mul_a = {prev_reg[31], prev_reg} + {err_reg[31], err_reg};
                mul_b = {16'b0, dt};
            end
            S_INCA:
            begin
                mul_a = 33'(err_reg);
                mul_b = 33'(gain_p_reg);
            end
            S_PA:
            begin
                mul_a = 33'(integ_reg);
                mul_b = 33'(gain_i_reg);
            end
            S_DW:
            begin
                mul_a = 33'(div_q);
                mul_b = 33'(gain_d_reg);
            end
            default: ;
        endcase
    end

    pidc_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // Q16.16 rescale toward zero, saturate; integral increment and clamp; drive limit clamp
    always_comb
    begin
        term_bias  = prod + (prod[pidc_pkg::ProdW-1] ? 66'sd65535 : 66'sd0);
        term_shift = term_bias >>> 16;
        if (term_shift > 66'sh7FFF_FFFF)
            term = 32'sh7FFF_FFFF;
        else if (term_shift < -66'sh8000_0000)
            term = 32'sh8000_0000;
        else
            term = term_shift[31:0];

        inc_bias  = prod + (prod[pidc_pkg::ProdW-1] ? 66'sd131071 : 66'sd0);
        inc_shift = inc_bias >>> 17;
        integ_sum = 35'(integ_reg) + inc_shift[34:0];
        if (integ_sum > pidc_pkg::IntegMax)
            integ_new = pidc_pkg::IntegW'(pidc_pkg::IntegMax);
        else if (integ_sum < -pidc_pkg::IntegMax)
            integ_new = pidc_pkg::IntegW'(-pidc_pkg::IntegMax);
        else
            integ_new = integ_sum[pidc_pkg::IntegW-1:0];

        lim = $signed({3'b0, out_limit_reg});
        if (acc_reg > lim)
            drive_w = lim;
        else if (acc_reg < -lim)
            drive_w = -lim;
        else
            drive_w = acc_reg;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_xfer) state_next = s_tuser[0] ? S_FIN : S_INC;
            S_INC:  state_next = S_INCA;
            S_INCA: state_next = S_PA;
            S_PA:   state_next = S_IA;
            S_IA:   state_next = S_DW;
            S_DW:   if (!div_busy) state_next = S_DA;
            S_DA:   state_next = S_FIN;
            S_FIN:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            prev_reg     <= '0;
            integ_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_FIN && out_free)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            if (s_xfer && s_tuser[0])
            begin
                prev_reg  <= '0;
                integ_reg <= '0;
            end
            if (state_reg == S_INCA)
            begin
                integ_reg <= integ_new;
                prev_reg  <= err_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            err_reg <= s_tuser[0] ? '0 : err_in;
            acc_reg <= '0;
        end
        case (state_reg)
            S_PA:    acc_reg <= 34'(term);
            S_IA:    acc_reg <= acc_reg + 34'(term);
            S_DA:    acc_reg <= acc_reg + 34'(term);
            default: ;
        endcase
        if (state_reg == S_FIN && out_free)
            m_tdata_reg <= {3'b0, integ_reg, err_reg, drive_w[31:0]};
    end

endmodule

>>> design/pidc_mul.sv
module pidc_mul (
    input  logic               clk,
    input  pidc_pkg::mul_op_t  op_a,
    input  pidc_pkg::mul_op_t  op_b,
    output pidc_pkg::mul_prod_t prod
);

    pidc_pkg::mul_prod_t prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

>>> design/pidc_div.sv
module pidc_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [pidc_pkg::DivNumW-1:0]        dividend,
    input  logic [pidc_pkg::DtW-1:0]            divisor,
    input  logic                                negative,
    output logic                                busy,
    output logic signed [pidc_pkg::DataW-1:0]   quotient
);

    logic                              busy_reg;
    logic                              fin_reg;
    logic [pidc_pkg::DivCntW-1:0]      cnt_reg;
    logic [pidc_pkg::DtW-1:0]          rem_reg;
    logic [pidc_pkg::DivNumW-1:0]      quo_reg;
    logic [pidc_pkg::DtW-1:0]          dvs_reg;
    logic                              neg_reg;
    logic signed [pidc_pkg::DataW-1:0] res_reg;

    logic [pidc_pkg::DtW:0]            shifted;
    logic [pidc_pkg::DtW:0]            trial;
    logic                              qbit;
    logic [pidc_pkg::DtW-1:0]          rem_next;
    logic signed [pidc_pkg::DataW-1:0] sat_next;

    // one restoring step per cycle
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[pidc_pkg::DivNumW-1]};
        trial    = shifted - {1'b0, dvs_reg};
        qbit     = ~trial[pidc_pkg::DtW];
        rem_next = qbit ? trial[pidc_pkg::DtW-1:0] : shifted[pidc_pkg::DtW-1:0];
    end

    // apply sign and saturate the magnitude to 32 bits
    always_comb
    begin
        if (neg_reg)
        begin
            if (quo_reg > pidc_pkg::DivNumW'(64'h8000_0000))
                sat_next = 32'sh8000_0000;
            else
                sat_next = -$signed(quo_reg[pidc_pkg::DataW-1:0]);
        end
        else
        begin
            if (quo_reg > pidc_pkg::DivNumW'(64'h7FFF_FFFF))
                sat_next = 32'sh7FFF_FFFF;
            else
                sat_next = $signed(quo_reg[pidc_pkg::DataW-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            fin_reg  <= 1'b0;
            cnt_reg  <= pidc_pkg::DivCntW'(pidc_pkg::DivSteps - 1);
        end
        else if (busy_reg)
        begin
            if (fin_reg)
            begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b0;
            end
            else
            begin
                if (cnt_reg == '0)
                    fin_reg <= 1'b1;
                else
                    cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
            neg_reg <= negative;
        end
        else if (busy_reg && !fin_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[pidc_pkg::DivNumW-2:0], qbit};
        end
        else if (busy_reg && fin_reg)
        begin
            res_reg <= sat_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = res_reg;

endmodule
